// File: rtl/fire_feedback_blur_macros.svh
// Assertion macros for the RTL, included by fire_feedback_blur. They sample on aclk and are disabled in reset.
`ifndef FIRE_FEEDBACK_BLUR_MACROS_SVH
`define FIRE_FEEDBACK_BLUR_MACROS_SVH

`define FBB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define FBB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define FBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbb_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = PIX_W + 3;
    localparam int AVG_SHIFT = 3;
    localparam int MIN_SIZE  = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int M_DATA_W  = 32;
    localparam int NUM_RES   = 3;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DECAY_AMOUNT = 2'd2;

    localparam logic [WIDTH_W-1:0] FRAME_WIDTH_RST  = WIDTH_W'(480);
    localparam logic [ROW_W-1:0]   FRAME_HEIGHT_RST = ROW_W'(360);
    localparam logic [PIX_W-1:0]   DECAY_AMOUNT_RST = PIX_W'(4);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t             pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/fbb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data_reg
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fire_feedback_blur.sv
`timescale 1ns / 1ps
`default_nettype none

// Fire blur over a raster pixel stream. Unless held, pixels enter one per clock in raster
// order over a frame of frame_width by frame_height; each interior pixel becomes the sum of
// its eight neighbors (above row and left taken from already blurred values, right and
// below row from originals) shifted right by three, minus decay_amount, clamped at zero,
// and every other pixel passes through. Results lag the input by one row and one column,
// each tagged with its row and column, and tlast marks the final pixel of the frame. A
// word that yields two or three results (the end of a row after the first row, or any
// column but the first on the last row) holds the input until all have left, since all
// results leave through a single output register; a stalled output holds it as well.
// Two 1024 by 8 line RAMs hold the previous row; they need no clearing after reset, so
// the block takes data as soon as reset is released. Sizes outside 4 to 1024 columns
// or below 4 rows are clamped.
module fire_feedback_blur
    import fbb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // APB configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    // Input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [PIX_W-1:0]    s_tdata,   // pixel_in
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,   // pixel_out, out_row, out_column, zero pad
    output logic                     m_tlast    // frame_last
);

    `include "fire_feedback_blur_macros.svh"

    logic [WIDTH_W-1:0] frame_width_reg;
    logic [ROW_W-1:0]   frame_height_reg;
    pix_t               decay_amount_reg;
    logic [WIDTH_W-1:0] width_eff;
    logic [ROW_W-1:0]   height_eff;
    logic               cfg_write;

    logic [COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [WIDTH_W-1:0] col_inc;
    logic [ROW_W:0]     row_inc;
    logic               accept;

    logic               s1_valid_reg, s1_valid_next;
    pix_t               s1_pix_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [NUM_RES-1:0] sent_reg, sent_next;

    pix_t               above;
    pix_t               orig;
    pix_t               in0_reg, in1_reg, abv0_reg, abv1_reg, org_reg, left_reg;

    logic               col_is_last;
    logic               interior;
    logic [NUM_RES-1:0] need, pend, pick, rest;
    logic [SUM_W-1:0]   sum;
    pix_t               avg;
    pix_t               blurred;
    pix_t               value;
    logic               out_free, out_load, retire;
    result_t            res_sel;

    logic               m_tvalid_reg, m_tvalid_next;
    result_t            m_res_reg;

    // Configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            decay_amount_reg <= DECAY_AMOUNT_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[ROW_W-1:0];
                REG_DECAY_AMOUNT: decay_amount_reg <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            REG_DECAY_AMOUNT: prdata = DATA_W'(decay_amount_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        priority if (frame_width_reg < WIDTH_W'(MIN_SIZE)) begin
            width_eff = WIDTH_W'(MIN_SIZE);
        end else if (frame_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            width_eff = frame_width_reg;
        end
        height_eff = (frame_height_reg < ROW_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : frame_height_reg;
    end

    // Raster position of the next input word
    assign accept  = s_tvalid && s_tready;
    assign col_inc = {1'b0, col_pos_reg} + WIDTH_W'(1);
    assign row_inc = {1'b0, row_pos_reg} + (ROW_W + 1)'(1);

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept) begin
            if (col_inc >= width_eff) begin
                col_pos_next = '0;
                row_pos_next = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_pos_next = col_inc[COL_W-1:0];
            end
        end
    end

    // Line buffers, read when a word is accepted and written when it retires
    fbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_final_line (
        .aclk        (aclk),
        .wr_en       (retire && need[0]),
        .wr_addr     (s1_col_reg - COL_W'(1)),
        .wr_data     (value),
        .rd_en       (accept),
        .rd_addr     (col_pos_reg),
        .rd_data_reg (above)
    );

    fbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_original_line (
        .aclk        (aclk),
        .wr_en       (retire),
        .wr_addr     (s1_col_reg),
        .wr_data     (s1_pix_reg),
        .rd_en       (accept),
        .rd_addr     (col_pos_reg),
        .rd_data_reg (orig)
    );

    // Blur of the pixel one row and one column behind the input word
    always_comb begin
        col_is_last = ({1'b0, s1_col_reg} == (width_eff - WIDTH_W'(1)));
        need[0]     = (s1_row_reg != '0) && (s1_col_reg != '0);
        need[1]     = (s1_row_reg != '0) && col_is_last;
        need[2]     = (s1_row_reg == (height_eff - ROW_W'(1)));
        interior    = (s1_row_reg >= ROW_W'(2)) && (s1_row_reg <= (height_eff - ROW_W'(2)))
                   && (s1_col_reg >= COL_W'(2))
                   && ({1'b0, s1_col_reg} <= (width_eff - WIDTH_W'(2)));
        sum = SUM_W'(abv1_reg) + SUM_W'(abv0_reg) + SUM_W'(above) + SUM_W'(left_reg)
            + SUM_W'(orig) + SUM_W'(in1_reg) + SUM_W'(in0_reg) + SUM_W'(s1_pix_reg);
        avg     = sum[AVG_SHIFT +: PIX_W];
        blurred = (avg > decay_amount_reg) ? (avg - decay_amount_reg) : '0;
        if (need[0]) begin
            value = interior ? blurred : org_reg;
        end else begin
            value = left_reg;
        end
    end

    // Results of the word in flight leave one per clock through the output register while m_tready does not stall it
    always_comb begin
        pend     = s1_valid_reg ? (need & ~sent_reg) : '0;
        pick     = pend & (~pend + NUM_RES'(1));
        rest     = pend & ~pick;
        out_free = !m_tvalid_reg || m_tready;
        out_load = (pend != '0) && out_free;
        retire   = s1_valid_reg && (rest == '0) && ((pend == '0) || out_free);
        s_tready = !s1_valid_reg || retire;

        priority if (pend[0]) begin
            res_sel = '{pixel: value, row: s1_row_reg - ROW_W'(1),
                        column: s1_col_reg - COL_W'(1), last: 1'b0};
        end else if (pend[1]) begin
            res_sel = '{pixel: orig, row: s1_row_reg - ROW_W'(1),
                        column: s1_col_reg, last: 1'b0};
        end else begin
            res_sel = '{pixel: s1_pix_reg, row: s1_row_reg,
                        column: s1_col_reg, last: col_is_last};
        end

        s1_valid_next = accept ? 1'b1 : (retire ? 1'b0 : s1_valid_reg);
        sent_next     = retire ? '0 : (out_load ? (sent_reg | pick) : sent_reg);
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            sent_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            in0_reg      <= '0;
            in1_reg      <= '0;
            abv0_reg     <= '0;
            abv1_reg     <= '0;
            org_reg      <= '0;
            left_reg     <= '0;
        end else begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            s1_valid_reg <= s1_valid_next;
            sent_reg     <= sent_next;
            m_tvalid_reg <= m_tvalid_next;
            if (retire) begin
                in1_reg  <= in0_reg;
                in0_reg  <= s1_pix_reg;
                abv1_reg <= abv0_reg;
                abv0_reg <= above;
                org_reg  <= orig;
                left_reg <= value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg <= s_tdata;
            s1_row_reg <= row_pos_reg;
            s1_col_reg <= col_pos_reg;
        end
        if (out_load) begin
            m_res_reg <= res_sel;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = M_DATA_W'({m_res_reg.column, m_res_reg.row, m_res_reg.pixel});

    `FBB_ASSERT_IMPLY(a_sent_clear_when_empty, !s1_valid_reg, sent_reg == '0,
        "results marked sent with no word in flight")
    `FBB_ASSERT_ALWAYS(a_pick_onehot, $onehot0(pick), "more than one result selected")
    `FBB_ASSERT_NEXT(a_stalled_word_holds, s1_valid_reg && !retire,
        s1_valid_reg && $stable(s1_col_reg) && $stable(s1_row_reg) && $stable(s1_pix_reg),
        "word in flight changed before retiring")

endmodule

`default_nettype wire
